@@ sv/psb_pkg.sv @@
// Package for the priority schedule builder: beat types, table entry type
// and shared constants. No dependencies.
`default_nettype none

package psb_pkg;

  localparam int unsigned MAX_PROCS_DEF = 32;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned TIME_W        = 22;
  localparam int unsigned SEG_MAX       = 63;

  typedef struct packed {
    logic [7:0]  proc_id;
    logic [15:0] ready_time;
    logic [15:0] burst_length;
    logic [7:0]  priority_level;
    logic        last_process;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]        segment_id;
    logic [TIME_W-1:0] segment_start;
    logic [15:0]       segment_length;
    logic              segment_last;
  } out_beat_t;

  typedef struct packed {
    logic             valid;
    logic             pending;
    logic [IDX_W-1:0] idx;
    logic [7:0]       pid;
    logic [15:0]      arrive;
    logic [15:0]      remain;
    logic [7:0]       prio;
  } entry_t;

endpackage

`default_nettype wire

@@ sv/psb_cell.sv @@
// One cell of the process ring: holds one table entry and hands it on.
// Depends on psb_pkg.
`default_nettype none

module psb_cell (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             shift_i,
  input  wire             clear_i,
  input  psb_pkg::entry_t d_i,
  output psb_pkg::entry_t q_o
);

  psb_pkg::entry_t ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (clear_i) begin
      ent_q.valid   <= 1'b0;
      ent_q.pending <= 1'b0;
    end else if (shift_i) begin
      ent_q <= d_i;
    end
  end

  assign q_o = ent_q;

endmodule

`default_nettype wire

@@ sv/priority_schedule_builder.sv @@
// Priority schedule builder top level: ring of entry cells plus the scan
// unit at its head. Depends on psb_pkg and psb_cell.
// Loading accepts one beat per cycle. After the last beat each segment costs
// a selection pass over the ring, a decide step, a second pass in preemptive
// mode and a produce step; an idle gap costs a selection pass and a decide step.
// A segment is released when the next one is produced or the schedule ends;
// input stalls until the final beat is handed over.
// Reset empties the ring, clears preemptive mode and returns to loading.
`default_nettype none

module priority_schedule_builder #(
  parameter int unsigned MaxProcs = psb_pkg::MAX_PROCS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  psb_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output psb_pkg::out_beat_t out_data_o,
  input  wire                cfg_we_i,
  input  wire                cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MaxProcs);
  localparam int unsigned LdW  = $clog2(MaxProcs + 1);
  localparam int unsigned TW   = psb_pkg::TIME_W;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SCAN, ST_DECIDE, ST_CUT, ST_PRODUCE, ST_FINAL
  } state_e;

  state_e state_q;
  logic            mode_q;
  logic [LdW-1:0]  count_q;
  logic [CntW-1:0] cnt_q;
  logic [TW-1:0]   clock_q, next_q, cut_q;
  logic [5:0]      k_q;
  logic            any_q, found_q;
  psb_pkg::entry_t pick_q;
  logic            upd_v_q, upd_done_q;
  logic [psb_pkg::IDX_W-1:0] upd_idx_q;
  logic [15:0]     upd_rem_q;
  logic            hold_v_q;
  psb_pkg::out_beat_t hold_q, out_q, fin_beat;
  logic            out_v_q;

  psb_pkg::entry_t chain [MaxProcs];
  psb_pkg::entry_t head, feed, new_ent;
  logic shift, clear, accept, out_free, better, cut_hit;
  logic [15:0] seg_len;

  // entry at the head, with last segment's outcome folded in
  always_comb begin
    head = chain[0];
    if (upd_v_q && head.valid && head.idx == upd_idx_q) begin
      if (upd_done_q) head.pending = 1'b0;
      else            head.remain  = upd_rem_q;
    end
  end

  always_comb begin
    new_ent.valid   = 1'b1;
    new_ent.pending = 1'b1;
    new_ent.idx     = psb_pkg::IDX_W'(count_q);
    new_ent.pid     = in_data_i.proc_id;
    new_ent.arrive  = in_data_i.ready_time;
    new_ent.remain  = in_data_i.burst_length;
    new_ent.prio    = in_data_i.priority_level;
  end

  // held segment marked as the final one of the schedule
  always_comb begin
    fin_beat              = hold_q;
    fin_beat.segment_last = 1'b1;
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_LOAD);
  assign shift      = (state_q == ST_SCAN) || (state_q == ST_CUT) ||
                      (accept && count_q < LdW'(MaxProcs));
  assign feed       = (state_q == ST_LOAD) ? new_ent : head;
  assign out_free   = !out_v_q || !out_stall_i;
  assign clear      = (state_q == ST_FINAL) && (!hold_v_q || out_free);

  for (genvar g = 0; g < MaxProcs; g++) begin : g_cell
    psb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .clear_i (clear),
      .d_i     ((g == MaxProcs - 1) ? feed : chain[(g + 1) % MaxProcs]),
      .q_o     (chain[g])
    );
  end

  // priority, then arrival, then load order
  always_comb begin
    if (head.prio != pick_q.prio)          better = head.prio < pick_q.prio;
    else if (head.arrive != pick_q.arrive) better = head.arrive < pick_q.arrive;
    else                                   better = head.idx < pick_q.idx;
  end

  assign cut_hit = head.valid && head.pending && head.idx != pick_q.idx &&
                   head.prio < pick_q.prio && TW'(head.arrive) > clock_q &&
                   TW'(head.arrive) < cut_q;
  assign seg_len = 16'(cut_q - clock_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      mode_q   <= 1'b0;
      count_q  <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      any_q    <= 1'b0;
      found_q  <= 1'b0;
      upd_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (state_q)
        ST_LOAD: begin
          if (accept) begin
            if (count_q < LdW'(MaxProcs)) count_q <= count_q + 1'b1;
            if (in_data_i.last_process) begin
              state_q  <= ST_SCAN;
              clock_q  <= '0;
              k_q      <= '0;
              hold_v_q <= 1'b0;
              upd_v_q  <= 1'b0;
              any_q    <= 1'b0;
              found_q  <= 1'b0;
              cnt_q    <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (head.valid && head.pending) begin
            any_q <= 1'b1;
            if (!any_q || TW'(head.arrive) < next_q) next_q <= TW'(head.arrive);
            if (TW'(head.arrive) <= clock_q && (!found_q || better)) begin
              found_q <= 1'b1;
              pick_q  <= head;
            end
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(MaxProcs - 1)) begin
            cnt_q   <= '0;
            upd_v_q <= 1'b0;
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          priority if (!any_q) begin
            state_q <= ST_FINAL;
          end else if (!found_q) begin
            clock_q <= next_q;
            any_q   <= 1'b0;
            state_q <= ST_SCAN;
          end else begin
            cut_q   <= clock_q + TW'(pick_q.remain);
            state_q <= mode_q ? ST_CUT : ST_PRODUCE;
          end
        end
        ST_CUT: begin
          if (cut_hit) cut_q <= TW'(head.arrive);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(MaxProcs - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_PRODUCE;
          end
        end
        ST_PRODUCE: begin
          if (!hold_v_q || out_free) begin
            if (hold_v_q) begin
              out_q   <= hold_q;
              out_v_q <= 1'b1;
            end
            hold_v_q                <= 1'b1;
            hold_q.segment_id       <= pick_q.pid;
            hold_q.segment_start    <= clock_q;
            hold_q.segment_length   <= seg_len;
            hold_q.segment_last     <= 1'b0;
            upd_v_q                 <= 1'b1;
            upd_idx_q               <= pick_q.idx;
            upd_done_q              <= (seg_len == pick_q.remain);
            upd_rem_q               <= pick_q.remain - seg_len;
            clock_q                 <= cut_q;
            k_q                     <= k_q + 1'b1;
            any_q                   <= 1'b0;
            found_q                 <= 1'b0;
            state_q <= (k_q == 6'(psb_pkg::SEG_MAX - 1)) ? ST_FINAL : ST_SCAN;
          end
        end
        ST_FINAL: begin
          if (!hold_v_q || out_free) begin
            if (hold_v_q) begin
              out_q   <= fin_beat;
              out_v_q <= 1'b1;
            end
            hold_v_q <= 1'b0;
            upd_v_q  <= 1'b0;
            count_q  <= '0;
            state_q  <= ST_LOAD;
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ bench/priority_schedule_builder_tb.sv @@
// Testbench for priority_schedule_builder: loads process sets, predicts the
// run segments of each schedule and checks every output beat against them.
// Depends on psb_pkg and the block's RTL.
`timescale 1ns / 100ps

module priority_schedule_builder_tb;

  localparam int unsigned NPROC = psb_pkg::MAX_PROCS_DEF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  psb_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  psb_pkg::out_beat_t out_data;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;

  always #5 clk = ~clk;

  priority_schedule_builder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // predictor state
  logic [7:0]        tab_pid[NPROC];
  logic [15:0]       tab_arr[NPROC];
  logic [15:0]       tab_rem[NPROC];
  logic [7:0]        tab_prio[NPROC];
  bit                tab_live[NPROC];
  int unsigned       n_loaded = 0;
  bit                preempt_on = 1'b0;

  psb_pkg::out_beat_t seg_queue[$];
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned segs_seen = 0;
  int unsigned sets_done = 0;
  bit          hold_off = 1'b0;
  int unsigned max_gap = 11;

  function automatic bit wins(int unsigned a, int unsigned b);
    if (tab_prio[a] != tab_prio[b]) return tab_prio[a] < tab_prio[b];
    if (tab_arr[a] != tab_arr[b]) return tab_arr[a] < tab_arr[b];
    return a < b;
  endfunction

  task automatic build_schedule();
    int unsigned now, pick, next_arr, start, rem, cut, len, k, i;
    bit any;
    psb_pkg::out_beat_t seg;
    k = 0;
    now = 0;
    while (k < psb_pkg::SEG_MAX) begin
      pick = NPROC;
      any = 1'b0;
      next_arr = 0;
      for (i = 0; i < n_loaded; i++) begin
        if (tab_live[i]) begin
          if (!any || tab_arr[i] < next_arr) next_arr = tab_arr[i];
          any = 1'b1;
          if (tab_arr[i] <= now && (pick == NPROC || wins(i, pick))) pick = i;
        end
      end
      if (!any) break;
      if (pick == NPROC) begin
        now = next_arr;
        continue;
      end
      start = now;
      rem = tab_rem[pick];
      len = rem;
      if (preempt_on) begin
        cut = start + rem;
        for (i = 0; i < n_loaded; i++)
          if (i != pick && tab_live[i] && tab_prio[i] < tab_prio[pick] &&
              tab_arr[i] > start && tab_arr[i] < cut)
            cut = tab_arr[i];
        len = cut - start;
      end
      seg.segment_id = tab_pid[pick];
      seg.segment_start = start[psb_pkg::TIME_W-1:0];
      seg.segment_length = len[15:0];
      seg.segment_last = 1'b0;
      seg_queue = {seg_queue, seg};
      k++;
      now = start + len;
      if (len == rem) tab_live[pick] = 1'b0;
      else tab_rem[pick] = 16'(rem - len);
    end
    if (k > 0) seg_queue[seg_queue.size()-1].segment_last = 1'b1;
    for (i = 0; i < NPROC; i++) tab_live[i] = 1'b0;
    n_loaded = 0;
    sets_done++;
  endtask

  task automatic absorb_beat(psb_pkg::in_beat_t b);
    if (n_loaded < NPROC) begin
      tab_pid[n_loaded] = b.proc_id;
      tab_arr[n_loaded] = b.ready_time;
      tab_rem[n_loaded] = b.burst_length;
      tab_prio[n_loaded] = b.priority_level;
      tab_live[n_loaded] = 1'b1;
      n_loaded++;
    end
    if (b.last_process) build_schedule();
  endtask

  // valid stays up after the accepting edge; it drops when a gap is drawn
  // or when the sender goes idle
  task automatic send_beat(psb_pkg::in_beat_t b);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_beat(b);
    beats_sent++;
  endtask

  // waits until the block is idle: all segments back, then a settling pause
  task automatic drain();
    in_valid <= 1'b0;
    while (seg_queue.size() != 0) @(posedge clk);
    repeat (4 * NPROC + 10) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    preempt_on = m;
  endtask

  function automatic psb_pkg::in_beat_t mk(logic [7:0] id, logic [15:0] arr,
                                           logic [15:0] bl, logic [7:0] pr, bit lst);
    psb_pkg::in_beat_t b;
    b.proc_id = id;
    b.ready_time = arr;
    b.burst_length = bl;
    b.priority_level = pr;
    b.last_process = lst;
    return b;
  endfunction

  // random set of n beats; unless wide, short times so arrivals and preemptions interleave
  task automatic random_set(int unsigned n, bit wide);
    int unsigned i;
    logic [15:0] a, bl;
    for (i = 0; i < n; i++) begin
      a = wide ? 16'($urandom) : 16'($urandom_range(0, 60));
      bl = wide ? 16'($urandom) : 16'($urandom_range(0, 20));
      send_beat(mk(8'($urandom), a, bl,
                   wide ? 8'($urandom) : 8'($urandom_range(0, 4)), i == n - 1));
    end
  endtask

  task automatic test_directed();
    set_mode(1'b0);
    send_beat(mk(8'h00, 16'd0, 16'd0, 8'h00, 1'b1));         // zero burst alone
    send_beat(mk(8'hff, 16'hffff, 16'hffff, 8'hff, 1'b0));   // extremes, idle jump
    send_beat(mk(8'h5a, 16'd0, 16'd5, 8'hff, 1'b0));
    send_beat(mk(8'ha5, 16'd0, 16'd5, 8'hff, 1'b1));         // tie on prio and arrival
    set_mode(1'b1);
    send_beat(mk(8'd1, 16'd0, 16'd10, 8'd5, 1'b0));
    send_beat(mk(8'd2, 16'd3, 16'd4, 8'd1, 1'b0));           // preempts at 3
    send_beat(mk(8'd3, 16'd5, 16'd2, 8'd0, 1'b0));           // preempts again
    send_beat(mk(8'd4, 16'd17, 16'd1, 8'd0, 1'b0));          // arrives once the rest are done
    send_beat(mk(8'd5, 16'd0, 16'd0, 8'd9, 1'b1));
    send_beat(mk(8'd6, 16'hffff, 16'hffff, 8'd0, 1'b0));
    send_beat(mk(8'd7, 16'd0, 16'hffff, 8'hff, 1'b1));
    set_mode(1'b0);
    send_beat(mk(8'd1, 16'd0, 16'd10, 8'd5, 1'b0));
    send_beat(mk(8'd2, 16'd3, 16'd4, 8'd1, 1'b1));
  endtask

  // overflow: 34 beats, the last two beyond capacity, the final one closes the set
  task automatic test_capacity();
    int unsigned i;
    set_mode(1'b1);
    for (i = 0; i < NPROC + 2; i++)
      send_beat(mk(8'(i), 16'($urandom_range(0, 200)), 16'($urandom_range(0, 30)),
                   8'($urandom_range(0, 7)), i == NPROC + 1));
  endtask

  task automatic test_random();
    int unsigned r;
    for (r = 0; r < 40; r++) begin
      if (r % 8 == 0) set_mode(r[3]);
      random_set($urandom_range(1, 8), $urandom_range(0, 5) == 0);
    end
  endtask

  // receiver holds off while the sender keeps offering, then sender waits
  task automatic test_backpressure();
    set_mode(1'b1);
    hold_off = 1'b1;
    random_set(6, 1'b0);
    random_set(5, 1'b0);
    hold_off = 1'b0;
    in_valid <= 1'b0;
    while (seg_queue.size() != 0) @(posedge clk);
    max_gap = 0;
    random_set(NPROC, 1'b0);
    max_gap = 11;
    set_mode(1'b0);
    random_set(NPROC, 1'b1);
  endtask

  // output stall: long hold-off on request, else random stalls between free stretches
  initial begin : stall_gen
    int unsigned n;
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
        while (hold_off) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        repeat (20) @(posedge clk);
      end else begin
        n = $urandom_range(0, 11);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    psb_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      segs_seen++;
      if (seg_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected segment %p", $time, out_data);
      end else begin
        want = seg_queue.pop_front();
        if (out_data.segment_id !== want.segment_id) begin
          errors++;
          $display("%0t: segment_id exp %0d got %0d", $time, want.segment_id,
                   out_data.segment_id);
        end
        if (out_data.segment_start !== want.segment_start) begin
          errors++;
          $display("%0t: segment_start exp %0d got %0d", $time, want.segment_start,
                   out_data.segment_start);
        end
        if (out_data.segment_length !== want.segment_length) begin
          errors++;
          $display("%0t: segment_length exp %0d got %0d", $time, want.segment_length,
                   out_data.segment_length);
        end
        if (out_data.segment_last !== want.segment_last) begin
          errors++;
          $display("%0t: segment_last exp %0d got %0d", $time, want.segment_last,
                   out_data.segment_last);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_random();
    test_backpressure();
    drain();
    if (seg_queue.size() != 0) errors++;
    $display("Covered %0d beats in %0d schedules, %0d segments checked,", beats_sent,
             sets_done, segs_seen);
    $display("both modes, capacity overflow, zero bursts and output back-pressure.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d segments outstanding", seg_queue.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/psb_pkg.sv
sv/psb_cell.sv
sv/priority_schedule_builder.sv
bench/priority_schedule_builder_tb.sv
